>>> hw/rtl/rrpa_pkg.sv
// Shared types and codes of the round-robin pull arbiter.
`timescale 1ns / 1ps

package rrpa_pkg;

	// Default number of arbitrated ports.
	localparam int RRPA_NUM_INPUTS = 8;

	// Width of the per-port data flags and of the port field on the stream.
	localparam int RRPA_DATA_W = 8;
	localparam int RRPA_PORT_W = 3;

	// Operation codes carried in the input beat.
	localparam logic [1:0] MODE_PULL    = 2'd0;
	localparam logic [1:0] MODE_UNBLOCK = 2'd1;
	localparam logic [1:0] MODE_ADD     = 2'd2;
	localparam logic [1:0] MODE_REMOVE  = 2'd3;

	// Commands broadcast to the port cells.
	localparam logic [2:0] OP_NOP     = 3'd0;
	localparam logic [2:0] OP_UNBLOCK = 3'd1;
	localparam logic [2:0] OP_ADD     = 3'd2;
	localparam logic [2:0] OP_REMOVE  = 3'd3;
	localparam logic [2:0] OP_LOAD    = 3'd4;
	localparam logic [2:0] OP_STEP    = 3'd5;

	typedef struct packed {
		logic [2:0]             op;
		logic [RRPA_PORT_W-1:0] port;
	} rrpa_cell_ctl_t;

	typedef struct packed {
		logic hit;          // token here, port eligible and has data
		logic blk;          // token here, port eligible but empty
		logic sel_present;  // addressed port is present
	} rrpa_cell_sts_t;

	// Result beat, grant_valid in the lowest bit.
	typedef struct packed {
		logic                   status;
		logic                   wake;
		logic                   underrun;
		logic [RRPA_PORT_W-1:0] grant_port;
		logic                   grant_valid;
	} rrpa_result_t;

endpackage

>>> hw/rtl/rrpa_cell.sv
// One port cell of the arbiter: presence, blocked flag and scan token.
`timescale 1ns / 1ps

module rrpa_cell import rrpa_pkg::*; #(
	parameter int IDX = 0,
	parameter int IW  = 3
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rrpa_cell_ctl_t         ctl,
	input  logic [IW-1:0]          start,
	input  logic [RRPA_DATA_W-1:0] has_data,
	input  logic                   token_in,
	output logic                   token_out,
	output rrpa_cell_sts_t         sts
);

	logic present_q;
	logic blocked_q;
	logic token_q;
	logic data_bit;
	logic match;
	logic eligible;
	logic stepping;

	generate
		if (IDX < RRPA_DATA_W) begin : g_data
			localparam int DI = IDX % RRPA_DATA_W;
			assign data_bit = has_data[DI];
			assign match    = (ctl.port == RRPA_PORT_W'(IDX));
		end else begin : g_nodata
			// Ports beyond the data field never have data and cannot be addressed.
			assign data_bit = 1'b0;
			assign match    = 1'b0;
		end
	endgenerate

	assign eligible        = present_q & ~blocked_q;
	assign stepping        = (ctl.op == OP_STEP);
	assign sts.hit         = stepping & token_q & eligible & data_bit;
	assign sts.blk         = stepping & token_q & eligible & ~data_bit;
	assign sts.sel_present = match & present_q;
	assign token_out       = token_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b1;
			blocked_q <= 1'b0;
			token_q   <= 1'b0;
		end else begin
			case (ctl.op)
				OP_UNBLOCK: begin
					if (match) blocked_q <= 1'b0;
				end
				OP_ADD: begin
					if (match) begin
						present_q <= 1'b1;
						blocked_q <= 1'b0;
					end
				end
				OP_REMOVE: begin
					if (match) begin
						present_q <= 1'b0;
						blocked_q <= 1'b0;
					end
				end
				OP_LOAD: begin
					token_q <= (start == IW'(IDX));
				end
				OP_STEP: begin
					token_q <= token_in;
					if (sts.blk) blocked_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/round_robin_pull_arbiter.sv
// Top level of the round-robin pull arbiter: command decode, scan control, result beat.
`timescale 1ns / 1ps

// A round-robin pull arbiter over NUM_INPUTS ports. Each input beat carries one
// command in s_tuser (pull, unblock, add or remove) with a port index and the
// per-port data flags in s_tdata; every command returns exactly one result beat.
// Each port lives in a cell of a ring that holds its presence and blocked flag.
// A pull drops a scan token into the cell at the round-robin pointer, and the
// token walks one cell per clock: a present, unblocked but empty port is marked
// blocked as the token passes, and the first such port with data is granted,
// which ends the scan and moves the pointer past it. If the token goes round the
// whole ring without a grant, the pull reports an underrun and is held pending
// until an unblock of a present port releases it with a wake. A pull holds
// off the next input beat while its token walks the ring in the scan state and
// its result waits in the done state; unblock, add and remove pass through the
// done state only. The result sits in an output register, so the next command is
// taken while an earlier result beat still waits for m_tready.
module round_robin_pull_arbiter import rrpa_pkg::*; #(
	parameter int NUM_INPUTS = RRPA_NUM_INPUTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [2:0] port, [10:3] has_data, [15:11] zero
	input  logic [1:0]  s_tuser,   // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [0] grant_valid, [3:1] grant_port, [4] underrun,
	                               // [5] wake, [6] status, [7] zero
);

	localparam int IW = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]             state_q;
	logic [IW-1:0]          cur_q;
	logic [IW-1:0]          cnt_q;
	logic [IW-1:0]          next_start_q;
	logic [IW-1:0]          last_blk_q;
	logic                   blk_any_q;
	logic                   pending_q;
	logic [RRPA_DATA_W-1:0] data_q;
	rrpa_result_t           res_q;
	rrpa_result_t           out_q;
	logic                   out_valid_q;

	logic                   accept;
	logic [1:0]             in_mode;
	logic [RRPA_PORT_W-1:0] in_port;
	logic [RRPA_DATA_W-1:0] in_has;
	rrpa_cell_ctl_t         ctl;
	logic [NUM_INPUTS-1:0]  tok;
	logic [NUM_INPUTS-1:0]  hit_vec;
	logic [NUM_INPUTS-1:0]  blk_vec;
	logic [NUM_INPUTS-1:0]  pres_vec;
	logic                   hit_any;
	logic                   blk_now;
	logic                   sel_pres;
	logic                   scan_last;
	logic                   out_free;
	logic                   out_load;
	rrpa_result_t           cmd_res;

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] x);
		logic [IW-1:0] r;
		if (x == IW'(NUM_INPUTS - 1)) r = '0;
		else r = x + 1'b1;
		return r;
	endfunction

	assign in_mode = s_tuser;
	assign in_port = s_tdata[2:0];
	assign in_has  = s_tdata[10:3];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign out_free = ~out_valid_q | m_tready;
	assign out_load = (state_q == ST_DONE) & out_free;

	// Command to the cells: the decoded mode on an accepted beat, a token step
	// while scanning, otherwise nothing.
	always_comb begin
		ctl.port = in_port;
		ctl.op   = OP_NOP;
		if (accept) begin
			case (in_mode)
				MODE_PULL:    ctl.op = OP_LOAD;
				MODE_UNBLOCK: ctl.op = OP_UNBLOCK;
				MODE_ADD:     ctl.op = OP_ADD;
				MODE_REMOVE:  ctl.op = OP_REMOVE;
				default:      ctl.op = OP_NOP;
			endcase
		end else if (state_q == ST_SCAN) begin
			ctl.op = OP_STEP;
		end
	end

	// Result of a command that finishes without a scan. An unblock of a present
	// port releases a held pull; a remove of an absent port reports status.
	always_comb begin
		cmd_res        = '0;
		cmd_res.wake   = (in_mode == MODE_UNBLOCK) & pending_q & sel_pres;
		cmd_res.status = (in_mode == MODE_REMOVE) & ~sel_pres;
	end

	genvar gi;
	generate
		for (gi = 0; gi < NUM_INPUTS; gi++) begin : g_cell
			rrpa_cell_sts_t sts;
			rrpa_cell #(
				.IDX (gi),
				.IW  (IW)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.start     (next_start_q),
				.has_data  (data_q),
				.token_in  (tok[(gi + NUM_INPUTS - 1) % NUM_INPUTS]),
				.token_out (tok[gi]),
				.sts       (sts)
			);
			assign hit_vec[gi]  = sts.hit;
			assign blk_vec[gi]  = sts.blk;
			assign pres_vec[gi] = sts.sel_present;
		end
	endgenerate

	assign hit_any   = |hit_vec;
	assign blk_now   = |blk_vec;
	assign sel_pres  = |pres_vec;
	assign scan_last = (cnt_q == IW'(NUM_INPUTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cur_q        <= '0;
			cnt_q        <= '0;
			next_start_q <= '0;
			last_blk_q   <= '0;
			blk_any_q    <= 1'b0;
			pending_q    <= 1'b0;
			data_q       <= '0;
			res_q        <= '0;
			out_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			out_valid_q <= out_load | (out_valid_q & ~m_tready);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_q <= cmd_res;
						case (in_mode)
							MODE_PULL: begin
								cur_q     <= next_start_q;
								cnt_q     <= '0;
								blk_any_q <= 1'b0;
								data_q    <= in_has;
								state_q   <= ST_SCAN;
							end
							MODE_UNBLOCK: begin
								// An unblock of a present port releases a held pull.
								if (pending_q && sel_pres) pending_q <= 1'b0;
								state_q <= ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (hit_any) begin
						res_q.grant_valid <= 1'b1;
						res_q.grant_port  <= RRPA_PORT_W'(cur_q);
						next_start_q      <= wrap_inc(cur_q);
						pending_q         <= 1'b0;
						state_q           <= ST_DONE;
					end else begin
						if (blk_now) begin
							blk_any_q  <= 1'b1;
							last_blk_q <= cur_q;
						end
						if (scan_last) begin
							res_q.underrun <= 1'b1;
							pending_q      <= 1'b1;
							// The pointer moves past the last port blocked by this pull.
							if (blk_now) next_start_q <= wrap_inc(cur_q);
							else if (blk_any_q) next_start_q <= wrap_inc(last_blk_q);
							state_q <= ST_DONE;
						end else begin
							cur_q <= wrap_inc(cur_q);
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_q   <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q};

endmodule

>>> hw/rtl/rrpa_checker.sv
// Port-level checks of the round-robin pull arbiter and their binding.
`timescale 1ns / 1ps

module rrpa_port_assertions (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata
);

	// A pull is either granted or reports an underrun, never both.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[4]))
		else $error("grant and underrun in the same result beat");

	// A granted pull carries no wake and no status.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> (m_tdata[5] == 1'b0 && m_tdata[6] == 1'b0))
		else $error("grant beat with wake or status set");

	// One command at a time: the input side closes after each accepted beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken again before the result was formed");

	// A stalled result beat holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result beat changed while stalled");

endmodule

bind round_robin_pull_arbiter rrpa_port_assertions u_rrpa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
